// ===== src/deq_pkg.sv =====
package deq_pkg;

  localparam int WORD_W   = 32;
  localparam int ACTION_W = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_BACK   = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_QUERY      = 3'd4
  } deq_action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE       = 2'd0,
    ST_POP_EMPTY  = 2'd1,
    ST_PUSH_FULL  = 2'd2
  } deq_status_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic front_in;
    logic front_out;
    logic back_in;
    logic back_out;
  } deq_ctrl_t;

endpackage

// ===== src/deq_if.sv =====
interface deq_in_if import deq_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [ACTION_W-1:0]      action;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

interface deq_out_if import deq_pkg::*; #(parameter int CNT_W = 5);
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] front_value;
  logic signed [WORD_W-1:0] back_value;
  logic [CNT_W-1:0]         entry_count;
  logic                     is_empty;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, front_value, back_value, entry_count, is_empty, status,
                  input ready);
  modport sink   (input valid, front_value, back_value, entry_count, is_empty, status,
                  output ready);
endinterface

// ===== src/deq_cell.sv =====
module deq_cell import deq_pkg::*; #(
  parameter int KEEP_W = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  deq_ctrl_t         ctrl,
  input  logic [KEEP_W-1:0] push_data,
  input  logic [KEEP_W-1:0] left_data,
  input  logic              left_valid,
  input  logic [KEEP_W-1:0] right_data,
  input  logic              right_valid,
  output logic [KEEP_W-1:0] data_r,
  output logic              valid_r
);

  logic [KEEP_W-1:0] data_nxt;
  logic              valid_nxt;

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (ctrl.front_in) begin
      data_nxt  = left_data;
      valid_nxt = left_valid;
    end else if (ctrl.front_out) begin
      data_nxt  = right_data;
      valid_nxt = right_valid;
    end else if (ctrl.back_in) begin
      // first free slot takes the word
      if (!valid_r && left_valid) begin
        data_nxt  = push_data;
        valid_nxt = 1'b1;
      end
    end else if (ctrl.back_out) begin
      if (valid_r && !right_valid) begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

// ===== src/double_ended_queue_core.sv =====
// channel   | port     | dir | payload
// ----------+----------+-----+-----------------------------------------------------
// request   | in_word  | in  | action, value
// result    | out_word | out | front_value, back_value, entry_count, is_empty, status
//
// one word per cycle: a request is taken whenever the result register is empty or
// being drained, and its result appears the next cycle
// the row of cells shifts as a whole for front operations; back operations touch
// only the cell at the boundary of the occupied run
// synchronous active-low reset empties the queue; no clearing pass
// a stalled result holds the state and the request side waits
module double_ended_queue_core import deq_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  deq_in_if.sink       in_word,
  deq_out_if.source    out_word
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int KEEP_W = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;

  logic [KEEP_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]  cell_valid;
  logic [DEPTH-1:0]  cell_tail;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  deq_status_t       status_r, status_nxt;
  deq_ctrl_t         ctrl;
  logic              accept;
  logic              full;
  logic              empty;
  logic [KEEP_W-1:0] push_data;
  logic [KEEP_W-1:0] front_sel;
  logic [KEEP_W-1:0] back_sel;

  assign in_word.ready = !out_valid_r || out_word.ready;
  assign accept        = in_word.valid && in_word.ready;
  assign full          = cell_valid[DEPTH-1];
  assign empty         = !cell_valid[0];
  assign push_data     = in_word.value[KEEP_W-1:0];

  always_comb begin
    ctrl       = '0;
    status_nxt = status_r;
    count_nxt  = count_r;
    if (accept) begin
      status_nxt = ST_DONE;
      case (in_word.action)
        ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
          if (full) begin
            status_nxt = ST_PUSH_FULL;
          end else begin
            ctrl.back_in  = (in_word.action == ACT_PUSH_BACK);
            ctrl.front_in = (in_word.action == ACT_PUSH_FRONT);
            count_nxt     = count_r + CNT_W'(1);
          end
        end
        ACT_POP_BACK, ACT_POP_FRONT: begin
          if (empty) begin
            status_nxt = ST_POP_EMPTY;
          end else begin
            ctrl.back_out  = (in_word.action == ACT_POP_BACK);
            ctrl.front_out = (in_word.action == ACT_POP_FRONT);
            count_nxt      = count_r - CNT_W'(1);
          end
        end
        default: begin
          status_nxt = ST_DONE;
        end
      endcase
    end
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic [KEEP_W-1:0] left_data;
      logic              left_valid;
      logic [KEEP_W-1:0] right_data;
      logic              right_valid;

      if (i == 0) begin : g_first
        assign left_data  = push_data;
        assign left_valid = 1'b1;
      end else begin : g_mid_l
        assign left_data  = cell_data[i-1];
        assign left_valid = cell_valid[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
        assign right_data  = '0;
        assign right_valid = 1'b0;
      end else begin : g_mid_r
        assign right_data  = cell_data[i+1];
        assign right_valid = cell_valid[i+1];
      end

      assign cell_tail[i] = cell_valid[i] && !right_valid;

      deq_cell #(.KEEP_W(KEEP_W)) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .push_data   (push_data),
        .left_data   (left_data),
        .left_valid  (left_valid),
        .right_data  (right_data),
        .right_valid (right_valid),
        .data_r      (cell_data[i]),
        .valid_r     (cell_valid[i])
      );
    end
  endgenerate

  // back entry is the one-hot boundary of the occupied run
  always_comb begin
    back_sel = '0;
    for (int k = 0; k < DEPTH; k++) begin
      back_sel = back_sel | (cell_data[k] & {KEEP_W{cell_tail[k]}});
    end
  end

  assign front_sel = cell_valid[0] ? cell_data[0] : '0;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_word.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
      status_r    <= ST_DONE;
    end else begin
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      status_r    <= status_nxt;
    end
  end

  assign out_word.valid       = out_valid_r;
  assign out_word.front_value = WORD_W'(front_sel);
  assign out_word.back_value  = WORD_W'(back_sel);
  assign out_word.entry_count = count_r;
  assign out_word.is_empty    = empty;
  assign out_word.status      = status_r;

endmodule

// ===== src/deq_checker.sv =====
module deq_checker import deq_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int CNT_W = 5
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [WORD_W-1:0] out_front_value,
  input logic signed [WORD_W-1:0] out_back_value,
  input logic [CNT_W-1:0]         out_entry_count,
  input logic                     out_is_empty,
  input logic [STATUS_W-1:0]      out_status
);

  // every taken word yields a result the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("no result after accepted word");

  // a stalled result does not change
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_front_value)
      && $stable(out_back_value) && $stable(out_entry_count) && $stable(out_status)))
    else $error("stalled result changed");

  // empty flag agrees with count and zeroed ends
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_entry_count == '0))
      && (!out_is_empty || (out_front_value == '0 && out_back_value == '0)))
    else $error("empty flag inconsistent");

  // push dropped only when full, pop ignored only when empty
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != ST_PUSH_FULL || out_entry_count == CNT_W'(DEPTH))
      && (out_status != ST_POP_EMPTY || out_entry_count == '0))
    else $error("status disagrees with count");

  // count never exceeds capacity
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= CNT_W'(DEPTH))
    else $error("count beyond depth");

endmodule

bind double_ended_queue_core deq_checker #(
  .DEPTH (DEPTH),
  .CNT_W (CNT_W)
) u_deq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_word.valid),
  .in_ready        (in_word.ready),
  .out_valid       (out_word.valid),
  .out_ready       (out_word.ready),
  .out_front_value (out_word.front_value),
  .out_back_value  (out_word.back_value),
  .out_entry_count (out_word.entry_count),
  .out_is_empty    (out_word.is_empty),
  .out_status      (out_word.status)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import deq_pkg::*;

  localparam int DEPTH           = 16;
  localparam int CNT_W           = 5;
  localparam int IDX_W           = $clog2(DEPTH);
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 8;
  localparam int PHASE_WORDS     = 575;
  localparam logic [ACTION_W-1:0] ACT_SPARE_TOP = '1;

  typedef struct {
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] back_value;
    logic [CNT_W-1:0]         entry_count;
    logic                     is_empty;
    deq_status_t              status;
  } deq_result_t;

  class deq_tracker;
    logic [WORD_W-1:0] cells [DEPTH];
    logic [IDX_W-1:0]  head;
    logic [IDX_W-1:0]  tail;
    int unsigned       held;
    deq_result_t       pending_results [$];
    int unsigned       mismatches;

    function new();
      head       = '0;
      tail       = '0;
      held       = 0;
      mismatches = 0;
    endfunction

    // apply one request to the shadow queue and queue the word it should produce
    function void note_request(logic [ACTION_W-1:0] action, logic [WORD_W-1:0] value);
      deq_result_t r;
      r.status = ST_DONE;
      case (action)
        ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
          if (held == DEPTH) begin
            r.status = ST_PUSH_FULL;
          end else if (action == ACT_PUSH_BACK) begin
            cells[tail] = value;
            tail++;
            held++;
          end else begin
            head--;
            cells[head] = value;
            held++;
          end
        end
        ACT_POP_BACK, ACT_POP_FRONT: begin
          if (held == 0) begin
            r.status = ST_POP_EMPTY;
          end else if (action == ACT_POP_BACK) begin
            tail--;
            held--;
          end else begin
            head++;
            held--;
          end
        end
        default: ;
      endcase
      r.entry_count = CNT_W'(held);
      r.is_empty    = (held == 0);
      if (held == 0) begin
        r.front_value = '0;
        r.back_value  = '0;
      end else begin
        r.front_value = cells[head];
        r.back_value  = cells[IDX_W'(tail - 1'b1)];
      end
      pending_results = {pending_results, r};
    endfunction

    function void check_result(logic signed [WORD_W-1:0] front_value,
                               logic signed [WORD_W-1:0] back_value,
                               logic [CNT_W-1:0] entry_count, logic is_empty,
                               logic [STATUS_W-1:0] status);
      deq_result_t e;
      if (pending_results.size() == 0) begin
        $error("result word with no expectation waiting");
        mismatches++;
        return;
      end
      e = pending_results[0];
      pending_results.delete(0);
      if (front_value !== e.front_value) begin
        $error("front_value: expected %0d, actual %0d", e.front_value, front_value);
        mismatches++;
      end
      if (back_value !== e.back_value) begin
        $error("back_value: expected %0d, actual %0d", e.back_value, back_value);
        mismatches++;
      end
      if (entry_count !== e.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", e.entry_count, entry_count);
        mismatches++;
      end
      if (is_empty !== e.is_empty) begin
        $error("is_empty: expected %0b, actual %0b", e.is_empty, is_empty);
        mismatches++;
      end
      if (status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, status);
        mismatches++;
      end
    endfunction

    function int unsigned waiting();
      return pending_results.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic        hold_start;
  int unsigned hold_left;
  int unsigned idle_cycles;
  deq_tracker  tracker;

  deq_in_if                    in_word ();
  deq_out_if #(.CNT_W(CNT_W))  out_word ();

  double_ended_queue_core #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (WORD_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .out_word (out_word)
  );

  always #2 clk = ~clk;

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_start) begin
      hold_left  = HOLD_OFF_CYCLES;
      hold_start = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_word.ready <= 1'b0;
    end else begin
      out_word.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // accepted words on both sides, plus watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_word.valid && in_word.ready)
        tracker.note_request(in_word.action, in_word.value);
      if (out_word.valid && out_word.ready)
        tracker.check_result(out_word.front_value, out_word.back_value,
                             out_word.entry_count, out_word.is_empty, out_word.status);
      if ((in_word.valid && in_word.ready) || (out_word.valid && out_word.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("double_ended_queue_core test failed");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [ACTION_W-1:0] action, input logic [WORD_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_word.valid <= 1'b0;
      @(posedge clk);
    end
    in_word.valid  <= 1'b1;
    in_word.action <= action;
    in_word.value  <= value;
    @(posedge clk);
    while (!in_word.ready) @(posedge clk);
  endtask

  task automatic send_random_word(input int unsigned push_pct);
    logic [ACTION_W-1:0] action;
    logic [WORD_W-1:0]   value;
    int unsigned         pick;
    pick = $urandom_range(99);
    if (pick < push_pct)
      action = $urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
    else if (pick < 90)
      action = $urandom_range(1) ? ACT_POP_FRONT : ACT_POP_BACK;
    else if (pick < 96)
      action = ACT_QUERY;
    else
      action = ACTION_W'($urandom_range(ACT_SPARE_TOP, ACT_QUERY + 1));
    case ($urandom_range(9))
      0:       value = {1'b1, {(WORD_W-1){1'b0}}};
      1:       value = {1'b0, {(WORD_W-1){1'b1}}};
      2:       value = '1;
      3:       value = '0;
      default: value = $urandom;
    endcase
    send_word(action, value);
  endtask

  // push-heavy, pop-heavy and balanced bursts so both full and empty are hit often
  task automatic send_random_words(input int unsigned count, input int unsigned hold_at);
    int unsigned push_pct;
    push_pct = 45;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 75;
          1:       push_pct = 20;
          default: push_pct = 45;
        endcase
      end
      if (i == hold_at) begin
        hold_start = 1'b1;
        push_pct   = 75;
      end
      send_random_word(push_pct);
    end
  endtask

  task automatic wait_for_drain();
    in_word.valid <= 1'b0;
    @(posedge clk);
    while (tracker.waiting() != 0) @(posedge clk);
  endtask

  initial begin
    tracker        = new();
    rst_n          = 1'b0;
    hold_start     = 1'b0;
    hold_left      = 0;
    idle_cycles    = 0;
    send_idle_pct  = 8;
    recv_idle_pct  = 70;
    in_word.valid  = 1'b0;
    in_word.action = ACT_QUERY;
    in_word.value  = '0;
    out_word.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty queue, pops on empty, spare codes
    send_word(ACT_QUERY, '0);
    send_word(ACT_POP_BACK, '1);
    send_word(ACT_POP_FRONT, '1);
    for (int unsigned a = ACT_QUERY + 1; a <= ACT_SPARE_TOP; a++)
      send_word(ACTION_W'(a), $urandom);
    // extremes at both ends
    send_word(ACT_PUSH_BACK, {1'b0, {(WORD_W-1){1'b1}}});
    send_word(ACT_PUSH_FRONT, {1'b1, {(WORD_W-1){1'b0}}});
    send_word(ACT_POP_BACK, '0);
    send_word(ACT_POP_FRONT, '0);
    send_word(ACT_PUSH_FRONT, '1);
    send_word(ACT_PUSH_BACK, '0);
    // fill up, wrapping the head index, then push on full
    for (int unsigned i = 0; i < DEPTH - 2; i++)
      send_word(i % 2 ? ACT_PUSH_FRONT : ACT_PUSH_BACK, $urandom);
    send_word(ACT_PUSH_BACK, $urandom);
    send_word(ACT_PUSH_FRONT, $urandom);
    send_word(ACT_POP_FRONT, '0);
    send_word(ACT_POP_BACK, '0);

    send_random_words(PHASE_WORDS, 100);
    wait_for_drain();

    send_idle_pct = 70;
    recv_idle_pct = 8;
    send_random_words(PHASE_WORDS, PHASE_WORDS);
    wait_for_drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_words(PHASE_WORDS, 200);
    wait_for_drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.waiting() == 0) begin
      $display("double_ended_queue_core test passed");
    end else begin
      $display("double_ended_queue_core test failed");
    end
    $finish;
  end

endmodule
